// ----- hw/rtl/bsq_pkg.sv -----
package bsq_pkg;

    localparam int BODY_COUNT = 256;
    localparam int BODY_AW    = $clog2(BODY_COUNT);

    localparam int VEL_W   = 16;
    localparam int TIMER_W = 24;
    localparam int SQ_W    = 32;
    localparam int CFG_IW  = 8;
    localparam int CFG_DW  = 24;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    localparam logic [CFG_IW-1:0] CFG_STEP_TIME     = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_LINEAR_LIMIT  = 8'd1;
    localparam logic [CFG_IW-1:0] CFG_ANGULAR_LIMIT = 8'd2;
    localparam logic [CFG_IW-1:0] CFG_SLEEP_TIME    = 8'd3;

    // operand selected for the shared squaring multiplier
    typedef enum logic [2:0] {
        OP_LIN_X,
        OP_LIN_Y,
        OP_LIN_Z,
        OP_ANG_X,
        OP_ANG_Y,
        OP_ANG_Z,
        OP_LIN_LIM,
        OP_ANG_LIM
    } bsq_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        bsq_op_t mul_sel;
        logic    acc_en;
        bsq_op_t acc_sel;
        logic    commit;
    } bsq_cmd_t;

endpackage

// ----- hw/rtl/bsq_ctrl.sv -----
module bsq_ctrl
    import bsq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output bsq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMMIT
    } state_t;

    localparam logic [3:0] LAST_STEP = 4'd8;

    state_t     state_reg;
    logic [3:0] step_reg;
    logic       m_valid_reg;
    logic [3:0] acc_step;
    logic       out_free;

    assign acc_step = step_reg - 4'd1;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.load    = s_valid && (state_reg == ST_IDLE);
        cmd.mul_en  = (state_reg == ST_MUL) && (step_reg < LAST_STEP);
        cmd.mul_sel = bsq_op_t'(step_reg[2:0]);
        cmd.acc_en  = (state_reg == ST_MUL) && (step_reg != 4'd0);
        cmd.acc_sel = bsq_op_t'(acc_step[2:0]);
        cmd.commit  = (state_reg == ST_COMMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= 4'd0;
                    if (s_valid) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_MUL && step_reg == 4'd0)
        else $error("request accepted but multiply sequence not started");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !m_valid_reg || m_ready)
        else $error("result overwritten before it was taken");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> step_reg <= LAST_STEP)
        else $error("multiply step counter ran past its end");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("commit did not raise the result");

endmodule

// ----- hw/rtl/bsq_dpath.sv -----
module bsq_dpath
    import bsq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  bsq_cmd_t            cmd,
    input  logic [7:0]          s_body_index,
    input  logic                s_is_dynamic,
    input  logic signed [15:0]  s_lin_vel_x,
    input  logic signed [15:0]  s_lin_vel_y,
    input  logic signed [15:0]  s_lin_vel_z,
    input  logic signed [15:0]  s_ang_vel_x,
    input  logic signed [15:0]  s_ang_vel_y,
    input  logic signed [15:0]  s_ang_vel_z,
    output logic [7:0]          m_body_out,
    output logic                m_asleep,
    output logic                m_zero_velocity,
    output logic                m_slow_now
);

    logic [15:0]        step_time_reg;
    logic [15:0]        linear_limit_reg;
    logic [15:0]        angular_limit_reg;
    logic [TIMER_W-1:0] sleep_time_reg;

    logic [7:0]              body_reg;
    logic                    dyn_reg;
    logic signed [VEL_W-1:0] vel_reg [6];

    logic signed [VEL_W:0]   mul_a;
    logic signed [2*VEL_W+1:0] prod_full;
    logic [SQ_W-1:0]         prod_reg;
    logic [SQ_W-1:0]         lin_sum_reg;
    logic [SQ_W-1:0]         ang_sum_reg;
    logic [SQ_W-1:0]         lin_lim_reg;
    logic [SQ_W-1:0]         ang_lim_reg;

    // timer and sleep flag share one word, valid bits stand for the reset clear
    logic [TIMER_W:0]   mem [BODY_COUNT];
    logic [BODY_COUNT-1:0] vld_reg;
    logic [TIMER_W:0]   rd_reg;
    logic               rd_vld_reg;

    logic [TIMER_W-1:0] timer_old;
    logic               flag_old;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_new;
    logic               reached;
    logic               slow;
    logic               idx_ok;
    logic               wr_en;
    logic [TIMER_W:0]   wr_data;
    logic               asleep_next;
    logic               zero_next;
    logic               slow_next;
    logic [BODY_AW-1:0] wr_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg     <= 16'd1092;
            linear_limit_reg  <= 16'd256;
            angular_limit_reg <= 16'd256;
            sleep_time_reg    <= 24'd32768;
        end else if (cfg_wr_en) begin
            priority case (cfg_index)
                CFG_STEP_TIME:     step_time_reg     <= cfg_wdata[15:0];
                CFG_LINEAR_LIMIT:  linear_limit_reg  <= cfg_wdata[15:0];
                CFG_ANGULAR_LIMIT: angular_limit_reg <= cfg_wdata[15:0];
                CFG_SLEEP_TIME:    sleep_time_reg    <= cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            body_reg   <= s_body_index;
            dyn_reg    <= s_is_dynamic;
            vel_reg[0] <= s_lin_vel_x;
            vel_reg[1] <= s_lin_vel_y;
            vel_reg[2] <= s_lin_vel_z;
            vel_reg[3] <= s_ang_vel_x;
            vel_reg[4] <= s_ang_vel_y;
            vel_reg[5] <= s_ang_vel_z;
            rd_reg     <= mem[s_body_index[BODY_AW-1:0]];
            rd_vld_reg <= vld_reg[s_body_index[BODY_AW-1:0]];
        end
    end

    always_comb begin
        unique case (cmd.mul_sel)
            OP_LIN_X:   mul_a = {vel_reg[0][VEL_W-1], vel_reg[0]};
            OP_LIN_Y:   mul_a = {vel_reg[1][VEL_W-1], vel_reg[1]};
            OP_LIN_Z:   mul_a = {vel_reg[2][VEL_W-1], vel_reg[2]};
            OP_ANG_X:   mul_a = {vel_reg[3][VEL_W-1], vel_reg[3]};
            OP_ANG_Y:   mul_a = {vel_reg[4][VEL_W-1], vel_reg[4]};
            OP_ANG_Z:   mul_a = {vel_reg[5][VEL_W-1], vel_reg[5]};
            OP_LIN_LIM: mul_a = {1'b0, linear_limit_reg};
            OP_ANG_LIM: mul_a = {1'b0, angular_limit_reg};
            default:    mul_a = '0;
        endcase
    end

    // a square is never negative, so the low bits are the magnitude
    assign prod_full = mul_a * mul_a;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_full[SQ_W-1:0];
        end
        if (cmd.acc_en) begin
            unique case (cmd.acc_sel)
                OP_LIN_X:   lin_sum_reg <= prod_reg;
                OP_LIN_Y:   lin_sum_reg <= lin_sum_reg + prod_reg;
                OP_LIN_Z:   lin_sum_reg <= lin_sum_reg + prod_reg;
                OP_ANG_X:   ang_sum_reg <= prod_reg;
                OP_ANG_Y:   ang_sum_reg <= ang_sum_reg + prod_reg;
                OP_ANG_Z:   ang_sum_reg <= ang_sum_reg + prod_reg;
                OP_LIN_LIM: lin_lim_reg <= prod_reg;
                OP_ANG_LIM: ang_lim_reg <= prod_reg;
                default: ;
            endcase
        end
    end

    always_comb begin
        timer_old = rd_vld_reg ? rd_reg[TIMER_W-1:0] : '0;
        flag_old  = rd_vld_reg ? rd_reg[TIMER_W] : 1'b0;
        timer_sum = {1'b0, timer_old} + {{(TIMER_W-15){1'b0}}, step_time_reg};
        timer_new = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
        reached   = (timer_new >= sleep_time_reg);
        slow      = (lin_sum_reg < lin_lim_reg) && (ang_sum_reg < ang_lim_reg);
        idx_ok    = (32'(body_reg) < BODY_COUNT);
        wr_addr   = body_reg[BODY_AW-1:0];

        wr_en       = 1'b0;
        wr_data     = '0;
        asleep_next = 1'b0;
        zero_next   = 1'b0;
        slow_next   = 1'b0;
        if (!dyn_reg) begin
            asleep_next = idx_ok && flag_old;
        end else begin
            slow_next = slow;
            if (idx_ok) begin
                wr_en = 1'b1;
                if (slow) begin
                    wr_data     = {flag_old || reached, timer_new};
                    zero_next   = reached;
                    asleep_next = flag_old || reached;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.commit && wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_body_out      <= body_reg;
            m_asleep        <= asleep_next;
            m_zero_velocity <= zero_next;
            m_slow_now      <= slow_next;
        end
    end

endmodule

// ----- hw/rtl/body_sleep_qualifier.sv -----
// sequence: the request is taken, eight squares pass through the shared multiplier,
// one last accumulate follows, then the commit registers the result once the sink
// has taken the previous one; no new request is taken until that commit
// per-body timer and flag live in a 256-entry memory with one valid bit per entry
// reset: synchronous active-low, clears control, valid bits and config registers
module body_sleep_qualifier
    import bsq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_body_index,
    input  logic               s_is_dynamic,
    input  logic signed [15:0] s_lin_vel_x,
    input  logic signed [15:0] s_lin_vel_y,
    input  logic signed [15:0] s_lin_vel_z,
    input  logic signed [15:0] s_ang_vel_x,
    input  logic signed [15:0] s_ang_vel_y,
    input  logic signed [15:0] s_ang_vel_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_body_out,
    output logic               m_asleep,
    output logic               m_zero_velocity,
    output logic               m_slow_now
);

    bsq_cmd_t cmd;

    bsq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bsq_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .s_body_index    (s_body_index),
        .s_is_dynamic    (s_is_dynamic),
        .s_lin_vel_x     (s_lin_vel_x),
        .s_lin_vel_y     (s_lin_vel_y),
        .s_lin_vel_z     (s_lin_vel_z),
        .s_ang_vel_x     (s_ang_vel_x),
        .s_ang_vel_y     (s_ang_vel_y),
        .s_ang_vel_z     (s_ang_vel_z),
        .m_body_out      (m_body_out),
        .m_asleep        (m_asleep),
        .m_zero_velocity (m_zero_velocity),
        .m_slow_now      (m_slow_now)
    );

endmodule

// ----- tb/sv/tb_body_sleep_qualifier.sv -----
module tb_body_sleep_qualifier;
    import bsq_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE_LOW = CFG_SLEEP_TIME + 8'd1;
    localparam logic [CFG_IW-1:0] CFG_SPARE_TOP = '1;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [7:0]         body;
        logic               dynamic;
        logic signed [15:0] lin_x;
        logic signed [15:0] lin_y;
        logic signed [15:0] lin_z;
        logic signed [15:0] ang_x;
        logic signed [15:0] ang_y;
        logic signed [15:0] ang_z;
    } body_req_t;

    typedef struct packed {
        logic [7:0] body;
        logic       asleep;
        logic       zero_vel;
        logic       slow;
    } body_status_t;

    typedef struct packed {
        logic              is_reg;
        logic [CFG_IW-1:0] reg_index;
        logic [CFG_DW-1:0] reg_data;
        body_req_t         req;
        logic              pinned;
        body_status_t      status;
    } probe_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]  cfg_index = '0;
    logic [CFG_DW-1:0]  cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_body_index = '0;
    logic               s_is_dynamic = 1'b0;
    logic signed [15:0] s_lin_vel_x = '0;
    logic signed [15:0] s_lin_vel_y = '0;
    logic signed [15:0] s_lin_vel_z = '0;
    logic signed [15:0] s_ang_vel_x = '0;
    logic signed [15:0] s_ang_vel_y = '0;
    logic signed [15:0] s_ang_vel_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_body_out;
    logic               m_asleep;
    logic               m_zero_velocity;
    logic               m_slow_now;

    // own copy of the configuration and the per-body stores
    logic [15:0]        step_time_q;
    logic [15:0]        lin_limit_q;
    logic [15:0]        ang_limit_q;
    logic [TIMER_W-1:0] sleep_time_q;
    logic [TIMER_W-1:0] rest_time_q [BODY_COUNT];
    logic               sleep_flag_q [BODY_COUNT];

    body_status_t expected_status [$];
    int mismatches = 0;
    int calm_left = 0;
    bit hold_request = 1'b0;

    body_sleep_qualifier uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_body_index    (s_body_index),
        .s_is_dynamic    (s_is_dynamic),
        .s_lin_vel_x     (s_lin_vel_x),
        .s_lin_vel_y     (s_lin_vel_y),
        .s_lin_vel_z     (s_lin_vel_z),
        .s_ang_vel_x     (s_ang_vel_x),
        .s_ang_vel_y     (s_ang_vel_y),
        .s_ang_vel_z     (s_ang_vel_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_body_out      (m_body_out),
        .m_asleep        (m_asleep),
        .m_zero_velocity (m_zero_velocity),
        .m_slow_now      (m_slow_now)
    );

    always #5 aclk = ~aclk;

    function automatic longint speed_sq(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z);
        return longint'(x) * x + longint'(y) * y + longint'(z) * z;
    endfunction

    function automatic body_status_t qualify_body(body_req_t r);
        body_status_t st;
        logic slow;
        logic [TIMER_W:0] sum;
        bit known;
        known = int'(r.body) < BODY_COUNT;
        slow = speed_sq(r.lin_x, r.lin_y, r.lin_z) < longint'(lin_limit_q) * lin_limit_q
            && speed_sq(r.ang_x, r.ang_y, r.ang_z) < longint'(ang_limit_q) * ang_limit_q;
        st = '0;
        st.body = r.body;
        if (!r.dynamic) begin
            if (known) st.asleep = sleep_flag_q[r.body];
        end else begin
            st.slow = slow;
            if (known) begin
                if (!slow) begin
                    rest_time_q[r.body] = '0;
                    sleep_flag_q[r.body] = 1'b0;
                end else begin
                    sum = {1'b0, rest_time_q[r.body]} + step_time_q;
                    rest_time_q[r.body] = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
                    if (rest_time_q[r.body] >= sleep_time_q) begin
                        sleep_flag_q[r.body] = 1'b1;
                        st.zero_vel = 1'b1;
                    end
                end
                st.asleep = sleep_flag_q[r.body];
            end
        end
        return st;
    endfunction

    function automatic probe_row_t req_row(logic [7:0] body, logic dynamic,
            int lx, int ly, int lz, int ax, int ay, int az,
            logic pinned, logic asleep, logic zero_vel, logic slow);
        probe_row_t row;
        row = '0;
        row.req = {body, dynamic, lx[15:0], ly[15:0], lz[15:0], ax[15:0], ay[15:0], az[15:0]};
        row.pinned = pinned;
        row.status = {body, asleep, zero_vel, slow};
        return row;
    endfunction

    function automatic probe_row_t reg_row(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        probe_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_index = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) calm_left = 30;
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // component small enough that three of them stay under the limit
    function automatic logic signed [15:0] slow_part(logic [15:0] limit);
        int h;
        int v;
        h = limit / 2;
        v = int'($urandom_range(0, 2 * h)) - h;
        return v[15:0];
    endfunction

    function automatic body_req_t random_request(int span);
        body_req_t r;
        int roll;
        int edge_val;
        if ($urandom_range(0, 9) == 0) r.body = 8'($urandom_range(0, 255));
        else r.body = 8'($urandom_range(0, span - 1));
        r.dynamic = $urandom_range(0, 9) != 0;
        r.lin_x = slow_part(lin_limit_q);
        r.lin_y = slow_part(lin_limit_q);
        r.lin_z = slow_part(lin_limit_q);
        r.ang_x = slow_part(ang_limit_q);
        r.ang_y = slow_part(ang_limit_q);
        r.ang_z = slow_part(ang_limit_q);
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
        end else if (roll < 85) begin
            // right on or just under the linear limit
            if (lin_limit_q <= 16'd32767) begin
                edge_val = int'(lin_limit_q) - int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1) edge_val = -edge_val;
                r.lin_x = edge_val[15:0];
                r.lin_y = '0;
                r.lin_z = '0;
            end
        end else if (roll < 90) begin
            r[95:48] = {$urandom(), 16'($urandom())};
        end else if (roll < 95) begin
            r[47:0] = {$urandom(), 16'($urandom())};
        end else begin
            r[95:0] = {$urandom(), $urandom(), $urandom()};
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_STEP_TIME:     step_time_q = data[15:0];
            CFG_LINEAR_LIMIT:  lin_limit_q = data[15:0];
            CFG_ANGULAR_LIMIT: ang_limit_q = data[15:0];
            CFG_SLEEP_TIME:    sleep_time_q = data[TIMER_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // block idle: no request offered, nothing outstanding, pipeline flushed
    task automatic settle_block();
        if (s_valid) s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_request(body_req_t r, logic pinned, body_status_t pinned_status);
        body_status_t predicted;
        int gap;
        s_valid      <= 1'b1;
        s_body_index <= r.body;
        s_is_dynamic <= r.dynamic;
        s_lin_vel_x  <= r.lin_x;
        s_lin_vel_y  <= r.lin_y;
        s_lin_vel_z  <= r.lin_z;
        s_ang_vel_x  <= r.ang_x;
        s_ang_vel_y  <= r.ang_y;
        s_ang_vel_z  <= r.ang_z;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        predicted = qualify_body(r);
        expected_status.insert(expected_status.size(), pinned ? pinned_status : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic random_phase(logic [15:0] step, logic [15:0] lin, logic [15:0] ang,
                                logic [TIMER_W-1:0] sleep, int count, int span, int hold_at);
        settle_block();
        write_reg(CFG_STEP_TIME, step);
        write_reg(CFG_LINEAR_LIMIT, lin);
        write_reg(CFG_ANGULAR_LIMIT, ang);
        write_reg(CFG_SLEEP_TIME, sleep);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                // sink stops for a long stretch while requests keep coming
                hold_request = 1'b1;
                calm_left = 60;
            end
            send_request(random_request(span), 1'b0, '0);
        end
    endtask

    // sink side
    initial begin
        int stall;
        int quiet;
        int roll;
        stall = 0;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (quiet > 0) begin
                    quiet--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) quiet = 50;
                    else if (roll < 55) stall = 0;
                    else if (roll < 85) stall = $urandom_range(1, 3);
                    else if (roll < 97) stall = $urandom_range(4, 20);
                    else stall = $urandom_range(40, 100);
                end
            end
        end
    end

    always @(posedge aclk) begin
        body_status_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: body %0d asleep %b zero %b slow %b",
                             m_body_out, m_asleep, m_zero_velocity, m_slow_now);
            end else begin
                want = expected_status.pop_front();
                if (m_body_out !== want.body || m_asleep !== want.asleep ||
                    m_zero_velocity !== want.zero_vel || m_slow_now !== want.slow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected body %0d asleep %b zero %b slow %b,",
                                 want.body, want.asleep, want.zero_vel, want.slow,
                                 " got body %0d asleep %b zero %b slow %b",
                                 m_body_out, m_asleep, m_zero_velocity, m_slow_now);
                end
            end
        end
    end

    initial begin
        probe_row_t probe_table [$];
        int waited;
        step_time_q  = 16'd1092;
        lin_limit_q  = 16'd256;
        ang_limit_q  = 16'd256;
        sleep_time_q = 24'd32768;
        foreach (rest_time_q[i]) begin
            rest_time_q[i] = '0;
            sleep_flag_q[i] = 1'b0;
        end
        probe_table = '{
            // reset settings: unit speed limits, about thirty slow steps to sleep
            req_row(0,   1, 0, 0, 0, 0, 0, 0,                          1, 0, 0, 1),
            req_row(255, 1, 0, 0, 0, 0, 0, 0,                          1, 0, 0, 1),
            req_row(0,   0, 32767, 32767, 32767, -32768, -32768, -32768, 1, 0, 0, 0),
            req_row(1,   1, -32768, 0, 0, 0, 0, 0,                     1, 0, 0, 0),
            req_row(1,   1, 0, 0, 0, 0, 0, 32767,                      1, 0, 0, 0),
            req_row(2,   1, 255, 0, 0, 0, 0, 0,                        1, 0, 0, 1),
            req_row(2,   1, 256, 0, 0, 0, 0, 0,                        1, 0, 0, 0),
            req_row(2,   1, 148, -148, 148, 0, 0, 0,                   1, 0, 0, 0),
            req_row(2,   1, 0, 0, 0, 147, -147, 147,                   1, 0, 0, 1),
            // zero sleep time, zero step: first slow update sleeps
            reg_row(CFG_SLEEP_TIME, 24'd0),
            reg_row(CFG_STEP_TIME, 24'd0),
            req_row(3,   1, 0, 0, 0, 0, 0, 0,                          1, 1, 1, 1),
            req_row(3,   0, 100, 0, 0, 0, 0, 0,                        1, 1, 0, 0),
            req_row(3,   1, 0, 0, 0, 0, 0, 0,                          1, 1, 1, 1),
            req_row(3,   1, -32768, 0, 0, 0, 0, 0,                     1, 0, 0, 0),
            req_row(3,   0, 0, 0, 0, 0, 0, 0,                          1, 0, 0, 0),
            // zero limit: strict compare, nothing is slow
            reg_row(CFG_LINEAR_LIMIT, 24'd0),
            req_row(4,   1, 0, 0, 0, 0, 0, 0,                          1, 0, 0, 0),
            // top values, spare indexes and bits above the register width
            reg_row(CFG_LINEAR_LIMIT, 24'hFFFFFF),
            reg_row(CFG_ANGULAR_LIMIT, 24'h00FFFF),
            reg_row(CFG_SPARE_LOW, 24'h123456),
            reg_row(CFG_SPARE_TOP, 24'hFFFFFF),
            reg_row(CFG_SLEEP_TIME, 24'hFFFFFF),
            reg_row(CFG_STEP_TIME, 24'hFFFFFF),
            req_row(5,   1, -32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0, 1),
            req_row(5,   1, 32767, 32767, 32767, 32767, 32767, 32767,  0, 0, 0, 0),
            req_row(255, 1, 1, -1, 1, -1, 1, -1,                       0, 0, 0, 0),
            req_row(128, 0, -32768, 32767, -1, 1, -32768, 32767,       0, 0, 0, 0)
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (probe_table[i]) begin
            if (probe_table[i].is_reg) begin
                settle_block();
                write_reg(probe_table[i].reg_index, probe_table[i].reg_data);
            end else begin
                send_request(probe_table[i].req, probe_table[i].pinned, probe_table[i].status);
            end
        end
        random_phase(16'd4096, 16'd256, 16'd256, 24'd32768, 200, 4, -1);
        // one body, largest step: timer runs into saturation at the top sleep time
        random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 360, 1, -1);
        random_phase(16'd0, 16'd0, 16'd0, 24'd0, 100, 8, -1);
        random_phase(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
                     16'($urandom_range(1, 16'hFFFF)),
                     24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(4, 14)),
                     240, 6, 60);
        random_phase(16'd1, 16'd1, 16'd1, 24'd0, 200, 4, -1);
        random_phase(16'd1092, 16'h8000, 16'h0100, 24'd10920, 200, 3, -1);
        if (s_valid) s_valid <= 1'b0;
        waited = 0;
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_status.size() != 0) begin
            $display("%0d results never arrived", expected_status.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
